// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the checker RTL; empty bodies under SYNTH
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_IMPLY(name, clk, rst, ante, cons)

`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== hdl/pfc_pkg.sv =====
// ----------------------------------------------------------------------------
// pfc_pkg
// Types and constants of the prefix-free code checker
// ----------------------------------------------------------------------------
package pfc_pkg;

   // word field widths
   localparam int CODE_W        = 10;
   localparam int LEN_W         = 4;
   localparam int SET_W         = 16;

   // longest codeword and the derived mark store geometry
   localparam int MAX_CODE_BITS = 10;
   localparam int NODE_W        = MAX_CODE_BITS + 1;
   localparam int MARK_ENTRIES  = (2 ** (MAX_CODE_BITS + 1)) - 2;
   localparam int MARK_AW       = $clog2(MARK_ENTRIES);
   localparam int POS_W         = $clog2(MAX_CODE_BITS);

   // set tag kept with each entry, zero never matches a live set
   localparam int EPOCH_W       = 8;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_WALK,
      S_DRAIN,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic [EPOCH_W-1:0] tag;
      logic               path;
      logic               stop;
   } mark_entry_type;

   typedef struct packed {
      logic load;
      logic step;
   } walk_ctrl_type;

   typedef struct packed {
      logic [MARK_AW-1:0] rd_addr;
      logic               final_step;
   } walk_sts_type;

endpackage

// ===== hdl/pfc_if.sv =====
// ----------------------------------------------------------------------------
// pfc_if
// Valid/ready channels for codeword words and verdict words
// ----------------------------------------------------------------------------
interface pfc_req_if;
   logic                        valid;
   logic                        ready;
   logic [pfc_pkg::CODE_W-1:0]  code_bits;
   logic [pfc_pkg::LEN_W-1:0]   code_length;
   logic                        last_of_set;

   modport source (output valid, output code_bits, output code_length,
                   output last_of_set, input ready);
   modport sink   (input valid, input code_bits, input code_length,
                   input last_of_set, output ready);
endinterface

interface pfc_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        decodable;
   logic [pfc_pkg::SET_W-1:0]   set_number;

   modport source (output valid, output decodable, output set_number, input ready);
   modport sink   (input valid, input decodable, input set_number, output ready);
endinterface

// ===== hdl/pfc_mark_store.sv =====
// ----------------------------------------------------------------------------
// pfc_mark_store
// Path and end marks per trie node, one write and one registered read a cycle
// ----------------------------------------------------------------------------
module pfc_mark_store (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [pfc_pkg::MARK_AW-1:0]     wr_addr,
   input  pfc_pkg::mark_entry_type         wr_data,
   input  logic                            rd_en,
   input  logic [pfc_pkg::MARK_AW-1:0]     rd_addr,
   output pfc_pkg::mark_entry_type         rd_data
);

   pfc_pkg::mark_entry_type mem [pfc_pkg::MARK_ENTRIES];
   pfc_pkg::mark_entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/pfc_path_walker.sv =====
// ----------------------------------------------------------------------------
// pfc_path_walker
// Walks one codeword down the trie, one depth per step, giving node addresses
// ----------------------------------------------------------------------------
module pfc_path_walker (
   input  logic                            clock,
   input  pfc_pkg::walk_ctrl_type          ctrl,
   input  logic [pfc_pkg::CODE_W-1:0]      code_bits,
   input  logic [pfc_pkg::LEN_W-1:0]       code_len,
   output pfc_pkg::walk_sts_type           sts
);

   logic [pfc_pkg::CODE_W-1:0] code_ff;
   logic [pfc_pkg::POS_W-1:0]  pos_ff;
   logic [pfc_pkg::NODE_W-1:0] node_ff;
   logic [pfc_pkg::NODE_W-1:0] node_in;
   logic                       bit_now;

   // heap node number: root is one, a child appends the next code bit
   assign bit_now = code_ff[pos_ff];
   assign node_in = {node_ff[pfc_pkg::NODE_W-2:0], bit_now};

   // store address is the node number less two (no entry for the root)
   assign sts.rd_addr    = pfc_pkg::MARK_AW'(node_in - pfc_pkg::NODE_W'(2));
   assign sts.final_step = (pos_ff == '0);

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         code_ff <= code_bits;
         pos_ff  <= pfc_pkg::POS_W'(code_len - pfc_pkg::LEN_W'(1));
         node_ff <= pfc_pkg::NODE_W'(1);
      end else if (ctrl.step) begin
         node_ff <= node_in;
         pos_ff  <= pos_ff - pfc_pkg::POS_W'(1);
      end
   end

endmodule

// ===== hdl/prefix_free_code_checker.sv =====
// ----------------------------------------------------------------------------
// prefix_free_code_checker
// Checks that a set of binary codewords is prefix free; one verdict per set
// ----------------------------------------------------------------------------
//  channel   dir  word contents
//  req_ch    in   code_bits, code_length, last_of_set
//  rsp_ch    out  decodable, set_number (only on the last word of a set)
//
//  a codeword of length n walks n trie steps, one per cycle, through the mark
//  store's read port, then drains; a last word then goes on to emit the verdict,
//  which waits for a free output register; a zero-length word takes no trie step
//  after reset, and after every 255 sets, a clearing pass over all 2046 entries
//  of the mark store runs; no word is taken meanwhile
//  a verdict waits in the output register; the next set's words are still taken
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module prefix_free_code_checker (
   input  logic          clock,
   input  logic          reset,
   pfc_req_if.sink       req_ch,
   pfc_rsp_if.source     rsp_ch
);

   pfc_pkg::state_type              state_ff, state_in;
   pfc_pkg::walk_ctrl_type          walk_ctrl;
   pfc_pkg::walk_sts_type           walk_sts;
   pfc_pkg::mark_entry_type         rd_data;
   pfc_pkg::mark_entry_type         wr_data;

   logic [pfc_pkg::LEN_W-1:0]       len_sat;
   logic                            req_fire;
   logic                            last_ff, last_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [pfc_pkg::MARK_AW-1:0]     chk_addr_ff;
   logic                            chk_final_ff;
   logic                            conflict_ff, conflict_in;
   logic [pfc_pkg::EPOCH_W-1:0]     epoch_ff, epoch_in;
   logic [pfc_pkg::MARK_AW-1:0]     clr_ff, clr_in;
   logic [pfc_pkg::SET_W-1:0]       set_count_ff, set_count_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            rsp_decodable_ff;
   logic [pfc_pkg::SET_W-1:0]       rsp_set_number_ff;
   logic                            rsp_load;
   logic                            out_free;
   logic                            entry_live;
   logic                            hit;
   logic                            wr_en;
   logic [pfc_pkg::MARK_AW-1:0]     wr_addr;
   logic                            rd_en;

   // saturate overlong codewords
   assign len_sat = (req_ch.code_length > pfc_pkg::LEN_W'(pfc_pkg::MAX_CODE_BITS)) ?
                    pfc_pkg::LEN_W'(pfc_pkg::MAX_CODE_BITS) : req_ch.code_length;

   assign req_ch.ready = (state_ff == pfc_pkg::S_IDLE);
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   // trie walker
   pfc_path_walker u_walker (
      .clock     (clock),
      .ctrl      (walk_ctrl),
      .code_bits (req_ch.code_bits),
      .code_len  (len_sat),
      .sts       (walk_sts)
   );

   // check stage: entry is only live when tagged with the current set
   assign entry_live = (rd_data.tag == epoch_ff);
   assign hit        = entry_live && (rd_data.stop || (chk_final_ff && rd_data.path));

   // write mux: clearing pass or update of the checked node
   always_comb begin
      if (state_ff == pfc_pkg::S_CLEAR) begin
         wr_en        = 1'b1;
         wr_addr      = clr_ff;
         wr_data.tag  = '0;
         wr_data.path = 1'b0;
         wr_data.stop = 1'b0;
      end else begin
         wr_en        = chk_valid_ff;
         wr_addr      = chk_addr_ff;
         wr_data.tag  = epoch_ff;
         wr_data.path = 1'b1;
         wr_data.stop = chk_final_ff || (entry_live && rd_data.stop);
      end
   end

   assign rd_en = (state_ff == pfc_pkg::S_WALK);

   pfc_mark_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (walk_sts.rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: next state and controls
   always_comb begin
      state_in       = state_ff;
      walk_ctrl.load = 1'b0;
      walk_ctrl.step = 1'b0;
      last_in        = last_ff;
      chk_valid_in   = 1'b0;
      clr_in         = clr_ff;
      epoch_in       = epoch_ff;
      rsp_load       = 1'b0;
      case (state_ff)
         pfc_pkg::S_CLEAR: begin
            clr_in = clr_ff + pfc_pkg::MARK_AW'(1);
            if (clr_ff == pfc_pkg::MARK_AW'(pfc_pkg::MARK_ENTRIES - 1)) begin
               clr_in   = '0;
               state_in = pfc_pkg::S_IDLE;
            end
         end
         pfc_pkg::S_IDLE: begin
            if (req_fire) begin
               walk_ctrl.load = 1'b1;
               last_in        = req_ch.last_of_set;
               if (len_sat != '0) begin
                  state_in = pfc_pkg::S_WALK;
               end else if (req_ch.last_of_set) begin
                  state_in = pfc_pkg::S_EMIT;
               end
            end
         end
         pfc_pkg::S_WALK: begin
            walk_ctrl.step = 1'b1;
            chk_valid_in   = 1'b1;
            if (walk_sts.final_step) begin
               state_in = pfc_pkg::S_DRAIN;
            end
         end
         pfc_pkg::S_DRAIN: begin
            state_in = last_ff ? pfc_pkg::S_EMIT : pfc_pkg::S_IDLE;
         end
         pfc_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (epoch_ff == '1) begin
                  epoch_in = pfc_pkg::EPOCH_W'(1);
                  state_in = pfc_pkg::S_CLEAR;
               end else begin
                  epoch_in = epoch_ff + pfc_pkg::EPOCH_W'(1);
                  state_in = pfc_pkg::S_IDLE;
               end
            end
         end
         default: begin
            state_in = pfc_pkg::S_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // conflict flag, set counter and output word
   always_comb begin
      conflict_in  = conflict_ff;
      set_count_in = set_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      if (chk_valid_ff && hit) begin
         conflict_in = 1'b1;
      end
      if (rsp_load) begin
         conflict_in  = 1'b0;
         set_count_in = set_count_ff + pfc_pkg::SET_W'(1);
         rsp_valid_in = 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfc_pkg::S_CLEAR;
         chk_valid_ff <= 1'b0;
         conflict_ff  <= 1'b0;
         epoch_ff     <= pfc_pkg::EPOCH_W'(1);
         clr_ff       <= '0;
         set_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         chk_valid_ff <= chk_valid_in;
         conflict_ff  <= conflict_in;
         epoch_ff     <= epoch_in;
         clr_ff       <= clr_in;
         set_count_ff <= set_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      chk_addr_ff  <= walk_sts.rd_addr;
      chk_final_ff <= walk_sts.final_step;
      if (rsp_load) begin
         rsp_decodable_ff  <= !conflict_ff;
         rsp_set_number_ff <= set_count_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.decodable  = rsp_decodable_ff;
   assign rsp_ch.set_number = rsp_set_number_ff;

   // checks
   `ASSERT_IMPLY(a_no_check_in_clear, clock, reset, state_ff == pfc_pkg::S_CLEAR, !chk_valid_ff)
   `ASSERT_IMPLY(a_epoch_nonzero, clock, reset, 1'b1, epoch_ff != '0)
   `ASSERT_NEXT(a_emit_loads_word, clock, reset, rsp_load, rsp_valid_ff)
   `ASSERT_NEXT(a_walk_ends_in_drain, clock, reset, rd_en && walk_sts.final_step, state_ff == pfc_pkg::S_DRAIN)
   `ASSERT_IMPLY(a_idle_no_pending_check, clock, reset, req_ch.ready, !chk_valid_ff)

endmodule
